FILE: rtl/ffba_pkg.sv
// Package for the first-fit byte allocator: field widths, action codes and status codes.
// Used by the channel interfaces and the top level; depends on nothing.
package ffba_pkg;

	localparam int ACT_W   = 2;
	localparam int ADDR_W  = 10;
	localparam int LEN_W   = 11;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 2;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam action_t ACT_ALLOC = 2'd0;
	localparam action_t ACT_FREE  = 2'd1;
	localparam action_t ACT_READ  = 2'd2;
	localparam action_t ACT_WRITE = 2'd3;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_ROOM = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;
	localparam status_t ST_ZERO    = 2'd3;

endpackage

FILE: rtl/ffba_req_if.sv
// Request channel of the first-fit byte allocator: valid, ready and the request fields.
// Depends on ffba_pkg for the field widths.
interface ffba_req_if;
	logic                          valid;
	logic                          ready;
	ffba_pkg::action_t             action;
	logic [ffba_pkg::ADDR_W-1:0]   address;
	logic [ffba_pkg::LEN_W-1:0]    length;
	logic [ffba_pkg::BYTE_W-1:0]   write_value;

	modport source (output valid, action, address, length, write_value, input ready);
	modport sink   (input valid, action, address, length, write_value, output ready);
endinterface

FILE: rtl/ffba_rsp_if.sv
// Response channel of the first-fit byte allocator: valid, ready and the result fields.
// Depends on ffba_pkg for the field widths.
interface ffba_rsp_if;
	logic                          valid;
	logic                          ready;
	ffba_pkg::status_t             status;
	logic [ffba_pkg::ADDR_W-1:0]   block_start;
	logic [ffba_pkg::BYTE_W-1:0]   read_value;

	modport source (output valid, status, block_start, read_value, input ready);
	modport sink   (input valid, status, block_start, read_value, output ready);
endinterface

FILE: rtl/first_fit_byte_allocator_unit.sv
// Top level of the first-fit byte allocator: byte store, used-map and their sequencer.
// Depends on ffba_pkg, ffba_req_if and ffba_rsp_if.
//
//   Port   Direction  Carries
//   req    sink       action, address, length, write_value
//   rsp    source     status, block_start, read_value
//
// After reset a clearing pass over every address zeroes both memories; req.ready stays low.
// A write is done from idle, a read uses the registered byte-store read, a free clears the
// bytes and map bits of its range, and an allocate scans the map (one map bit per cycle),
// then marks the run used. Rejected requests answer from idle. A new request is taken only
// when the sequencer is idle and the response register is empty or being drained.
module first_fit_byte_allocator_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	ffba_req_if.sink       req,
	ffba_rsp_if.source     rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (CW > ffba_pkg::ADDR_W + 2) ? CW : ffba_pkg::ADDR_W + 2;
	localparam int LW = ffba_pkg::LEN_W;
	localparam int BW = ffba_pkg::BYTE_W;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_SCAN = 6'b000100,
		S_MARK = 6'b001000,
		S_FREE = 6'b010000,
		S_READ = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       idx_q, idx_d;
	logic                pend_q, pend_d;
	logic                ov_q;
	logic [AW-1:0]       pidx_q, pidx_d;
	logic [LW-1:0]       run_q, run_d;
	logic [LW-1:0]       len_q, len_d;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic [AW-1:0]       end_q, end_d;
	logic [AW-1:0]       blk_q, blk_d;
	ffba_pkg::status_t   status_q;
	logic [AW-1:0]       start_q;
	logic [BW-1:0]       rdv_q;

	logic [BW-1:0]       byte_mem [CAPACITY];
	logic                used_mem [CAPACITY];
	logic [BW-1:0]       byte_rd_q;
	logic                used_rd_q;

	logic                b_we, b_re, u_we, u_re, u_wd;
	logic [AW-1:0]       b_wa, b_ra, u_wa, u_ra;
	logic [BW-1:0]       b_wd;

	logic                res_load;
	ffba_pkg::status_t   res_status;
	logic [AW-1:0]       res_start;
	logic [BW-1:0]       res_rdv;

	logic                out_free, accept, addr_ok;
	logic [SW-1:0]       addr_w, sum_w, last_w, fs_w;
	logic [LW-1:0]       run_nx;

	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign addr_w = SW'(req.address);
	assign sum_w = addr_w + SW'(req.length);
	assign last_w = sum_w - SW'(1);
	assign addr_ok = addr_w < SW'(CAPACITY);
	assign run_nx = used_rd_q ? '0 : run_q + LW'(1);
	assign fs_w = SW'(pidx_q) + SW'(1) - SW'(run_nx);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pend_d = 1'b0;
		pidx_d = pidx_q;
		run_d = run_q;
		len_d = len_q;
		ptr_d = ptr_q;
		end_d = end_q;
		blk_d = blk_q;
		b_we = 1'b0;
		b_wa = ptr_q;
		b_wd = '0;
		b_re = 1'b0;
		b_ra = addr_w[AW-1:0];
		u_we = 1'b0;
		u_wa = ptr_q;
		u_wd = 1'b0;
		u_re = 1'b0;
		u_ra = idx_q[AW-1:0];
		res_load = 1'b0;
		res_status = ffba_pkg::ST_OK;
		res_start = '0;
		res_rdv = '0;
		unique case (state_q)
			S_CLR: begin
				b_we = 1'b1;
				u_we = 1'b1;
				b_wa = idx_q[AW-1:0];
				u_wa = idx_q[AW-1:0];
				idx_d = idx_q + CW'(1);
				if (idx_q == CW'(CAPACITY - 1)) begin
					idx_d = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (req.action)
						ffba_pkg::ACT_ALLOC: begin
							if (req.length == '0) begin
								res_load = 1'b1;
								res_status = ffba_pkg::ST_ZERO;
							end else begin
								len_d = req.length;
								run_d = '0;
								idx_d = '0;
								state_d = S_SCAN;
							end
						end
						ffba_pkg::ACT_FREE: begin
							if (sum_w > SW'(CAPACITY)) begin
								res_load = 1'b1;
								res_status = ffba_pkg::ST_RANGE;
							end else if (req.length == '0) begin
								res_load = 1'b1;
							end else begin
								ptr_d = addr_w[AW-1:0];
								end_d = last_w[AW-1:0];
								state_d = S_FREE;
							end
						end
						ffba_pkg::ACT_READ: begin
							if (!addr_ok) begin
								res_load = 1'b1;
								res_status = ffba_pkg::ST_RANGE;
							end else begin
								b_re = 1'b1;
								state_d = S_READ;
							end
						end
						default: begin
							res_load = 1'b1;
							if (!addr_ok) begin
								res_status = ffba_pkg::ST_RANGE;
							end else begin
								b_we = 1'b1;
								b_wa = addr_w[AW-1:0];
								b_wd = req.write_value;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				if (idx_q != CW'(CAPACITY)) begin
					u_re = 1'b1;
					idx_d = idx_q + CW'(1);
					pend_d = 1'b1;
					pidx_d = idx_q[AW-1:0];
				end
				if (pend_q) begin
					run_d = run_nx;
					if (run_nx == len_q) begin
						ptr_d = fs_w[AW-1:0];
						blk_d = fs_w[AW-1:0];
						end_d = pidx_q;
						state_d = S_MARK;
					end
				end else if (idx_q == CW'(CAPACITY) && out_free) begin
					res_load = 1'b1;
					res_status = ffba_pkg::ST_NO_ROOM;
					state_d = S_IDLE;
				end
			end
			S_MARK: begin
				u_we = 1'b1;
				u_wd = 1'b1;
				if (ptr_q == end_q) begin
					if (out_free) begin
						res_load = 1'b1;
						res_start = blk_q;
						state_d = S_IDLE;
					end
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_FREE: begin
				b_we = 1'b1;
				u_we = 1'b1;
				if (ptr_q == end_q) begin
					if (out_free) begin
						res_load = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_READ: begin
				if (out_free) begin
					res_load = 1'b1;
					res_rdv = byte_rd_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			pend_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			pend_q <= pend_d;
			if (res_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_q <= pidx_d;
		run_q <= run_d;
		len_q <= len_d;
		ptr_q <= ptr_d;
		end_q <= end_d;
		blk_q <= blk_d;
		if (res_load) begin
			status_q <= res_status;
			start_q <= res_start;
			rdv_q <= res_rdv;
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			byte_mem[b_wa] <= b_wd;
		end
		if (b_re) begin
			byte_rd_q <= byte_mem[b_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			used_mem[u_wa] <= u_wd;
		end
		if (u_re) begin
			used_rd_q <= used_mem[u_ra];
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.status = status_q;
	assign rsp.block_start = ffba_pkg::ADDR_W'(start_q);
	assign rsp.read_value = rdv_q;

endmodule

FILE: test/ffba_checker.sv
// Checker for the first-fit byte allocator: keeps its own byte store and used-map,
// predicts the response to every request transaction and compares it with the response seen.
// Depends on ffba_pkg, ffba_req_if and ffba_rsp_if.
module ffba_checker #(
	parameter int CAPACITY = 1024
) (
	input  logic clk,
	input  logic arst_n,
	ffba_req_if  req,
	ffba_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		ffba_pkg::action_t             action;
		logic [ffba_pkg::ADDR_W-1:0]   address;
		logic [ffba_pkg::LEN_W-1:0]    length;
		logic [ffba_pkg::BYTE_W-1:0]   write_value;
	} byte_op_t;

	typedef struct packed {
		ffba_pkg::status_t             status;
		logic [ffba_pkg::ADDR_W-1:0]   block_start;
		logic [ffba_pkg::BYTE_W-1:0]   read_value;
	} reply_t;

	logic [ffba_pkg::BYTE_W-1:0] shadow_bytes [CAPACITY];
	bit                          shadow_used  [CAPACITY];
	reply_t                      replies_due  [$];

	function automatic reply_t serve_op(byte_op_t op);
		reply_t r;
		int     run;
		int     first;
		int     stop;
		r = '0;
		r.status = ffba_pkg::ST_OK;
		unique case (op.action)
		ffba_pkg::ACT_ALLOC: begin
			if (op.length == 0) begin
				r.status = ffba_pkg::ST_ZERO;
			end else begin
				r.status = ffba_pkg::ST_NO_ROOM;
				run = 0;
				for (int i = 0; i < CAPACITY; i++) begin
					run = shadow_used[i] ? 0 : run + 1;
					if (run == int'(op.length)) begin
						first = i + 1 - run;
						for (int k = first; k <= i; k++)
							shadow_used[k] = 1'b1;
						r.status = ffba_pkg::ST_OK;
						r.block_start = ffba_pkg::ADDR_W'(first);
						break;
					end
				end
			end
		end
		ffba_pkg::ACT_FREE: begin
			stop = int'(op.address) + int'(op.length);
			if (stop > CAPACITY) begin
				r.status = ffba_pkg::ST_RANGE;
			end else begin
				for (int i = int'(op.address); i < stop; i++) begin
					shadow_bytes[i] = '0;
					shadow_used[i] = 1'b0;
				end
			end
		end
		ffba_pkg::ACT_READ: begin
			if (int'(op.address) >= CAPACITY)
				r.status = ffba_pkg::ST_RANGE;
			else
				r.read_value = shadow_bytes[op.address];
		end
		default: begin
			if (int'(op.address) >= CAPACITY)
				r.status = ffba_pkg::ST_RANGE;
			else
				shadow_bytes[op.address] = op.write_value;
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t seen;
		reply_t due;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				shadow_bytes[i] = '0;
				shadow_used[i] = 1'b0;
			end
			replies_due.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen = {rsp.status, rsp.block_start, rsp.read_value};
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: response with no request outstanding: ",
							"status %0d start %0d data %0h"},
							$time, seen.status, seen.block_start, seen.read_value);
				end else begin
					due = replies_due.pop_front();
					if (seen != due) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: response mismatch: expected status %0d ",
								"start %0d data %0h, got status %0d start %0d data %0h"},
								$time, due.status, due.block_start, due.read_value,
								seen.status, seen.block_start, seen.read_value);
					end
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(serve_op({req.action, req.address, req.length,
					req.write_value}));
			outstanding <= replies_due.size();
		end
	end

endmodule

FILE: test/tb_first_fit_byte_allocator_unit.sv
// Testbench top for first_fit_byte_allocator_unit: clock, reset, request stimulus,
// response back-pressure, a stall watchdog and the verdict.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if, the allocator and ffba_checker.
module tb_first_fit_byte_allocator_unit;

	localparam int MEM_BYTES     = 1024;
	localparam int RANDOM_OPS    = 560;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 100;

	logic clk;
	logic arst_n;
	bit   steady;
	int   hold_asked  = 0;
	int   hold_served = 0;
	int   quiet_cycles = 0;
	int   mismatches;
	int   outstanding;

	int   written_addrs [$];

	ffba_req_if req();
	ffba_rsp_if rsp();

	first_fit_byte_allocator_unit #(.CAPACITY(MEM_BYTES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ffba_checker #(.CAPACITY(MEM_BYTES)) alloc_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic issue(input ffba_pkg::action_t act, input int addr,
		input int len, input int val);
		if (!steady && $urandom_range(99) < 23) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.action      <= act;
		req.address     <= ffba_pkg::ADDR_W'(addr);
		req.length      <= ffba_pkg::LEN_W'(len);
		req.write_value <= ffba_pkg::BYTE_W'(val);
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain_replies();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end else begin
				rsp.ready <= steady || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		ffba_pkg::action_t  act;
		int                 addr;
		int                 len;
		int                 val;
		int                 pick;

		steady          = 1'b0;
		arst_n          = 1'b0;
		req.valid       <= 1'b0;
		req.action      <= ffba_pkg::ACT_ALLOC;
		req.address     <= '0;
		req.length      <= '0;
		req.write_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		issue(ffba_pkg::ACT_ALLOC, 0, 0, 0);
		issue(ffba_pkg::ACT_READ, 0, 0, 0);
		issue(ffba_pkg::ACT_WRITE, 1023, 0, 8'hFF);
		issue(ffba_pkg::ACT_READ, 1023, 0, 0);
		issue(ffba_pkg::ACT_WRITE, 0, 0, 8'hA5);
		issue(ffba_pkg::ACT_WRITE, 1, 0, 8'h5A);
		issue(ffba_pkg::ACT_READ, 0, 0, 0);
		issue(ffba_pkg::ACT_READ, 1, 0, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 1, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 10, 0);
		issue(ffba_pkg::ACT_FREE, 0, 0, 0);
		issue(ffba_pkg::ACT_FREE, 1023, 2, 0);
		issue(ffba_pkg::ACT_FREE, 1, 1023, 0);
		issue(ffba_pkg::ACT_READ, 1, 0, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 1024, 0);
		issue(ffba_pkg::ACT_FREE, 0, 1024, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 1024, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 1, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 2047, 0);
		issue(ffba_pkg::ACT_FREE, 0, 2047, 0);
		issue(ffba_pkg::ACT_FREE, 1023, 1, 0);
		issue(ffba_pkg::ACT_ALLOC, 0, 1, 0);
		issue(ffba_pkg::ACT_WRITE, 512, 0, 8'h3C);
		issue(ffba_pkg::ACT_READ, 512, 0, 0);
		issue(ffba_pkg::ACT_FREE, 0, 1024, 0);
		issue(ffba_pkg::ACT_READ, 512, 0, 0);
		drain_replies();

		for (int n = 0; n < RANDOM_OPS; n++) begin
			steady = (n >= 300 && n < 420);
			if (n == 100)
				hold_asked++;
			if (n == 200)
				drain_replies();
			addr = $urandom_range(MEM_BYTES - 1);
			val  = $urandom_range(255);
			len  = 0;
			pick = $urandom_range(99);
			if (pick < 35) begin
				act  = ffba_pkg::ACT_ALLOC;
				pick = $urandom_range(99);
				if (pick < 2)
					len = 0;
				else if (pick < 72)
					len = $urandom_range(1, 16);
				else if (pick < 94)
					len = $urandom_range(17, 128);
				else if (pick < 98)
					len = $urandom_range(129, 1024);
				else
					len = $urandom_range(1025, 2047);
			end else if (pick < 60) begin
				act  = ffba_pkg::ACT_FREE;
				pick = $urandom_range(99);
				if (pick < 3) begin
					addr = 0;
					len  = MEM_BYTES;
				end else if (pick < 10) begin
					len = $urandom_range(0, 2047);
				end else if (pick < 30) begin
					len = $urandom_range(0, 256);
				end else begin
					len = $urandom_range(0, 48);
				end
			end else if (pick < 80) begin
				act = ffba_pkg::ACT_WRITE;
				if (written_addrs.size() != 0 && $urandom_range(1))
					addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
				written_addrs.push_back(addr);
				if (written_addrs.size() > 16)
					void'(written_addrs.pop_front());
			end else begin
				act = ffba_pkg::ACT_READ;
				if (written_addrs.size() != 0 && $urandom_range(99) < 60)
					addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
			end
			issue(act, addr, len, val);
		end

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ffba_pkg.sv
rtl/ffba_req_if.sv
rtl/ffba_rsp_if.sv
rtl/first_fit_byte_allocator_unit.sv
test/ffba_checker.sv
test/tb_first_fit_byte_allocator_unit.sv
